/* sv/waveform_pulse_trigger_unit_assert.svh */
// Assertion macros shared by the checker of the pulse trigger unit.
`ifndef WAVEFORM_PULSE_TRIGGER_UNIT_ASSERT_SVH
`define WAVEFORM_PULSE_TRIGGER_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define WPTU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define WPTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wptu_pkg.sv */
// Package of the pulse trigger unit: payload types, register codes, states.
package wptu_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = 12;
    localparam int COUNT_BITS  = 13;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW    = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXCL_PRE  = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXCL_POST = 8'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [IDX_BITS-1:0]           max_index;
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic                          fired;
        logic signed [SAMPLE_BITS-1:0] baseline;
        logic [COUNT_BITS-1:0]         sample_count;
        logic                          overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_RHS,
        ST_PASS,
        ST_WAIT,
        ST_BDIV,
        ST_OUT
    } state_t;

endpackage

/* sv/wptu_mem.sv */
// Sample store: one write port, two registered read ports.
module wptu_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [W-1:0]  rdata_a,
    output logic [W-1:0]  rdata_b
);

    logic [W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* sv/wptu_div.sv */
// Radix-2 restoring divider giving the floor quotient of a signed dividend.
module wptu_div #(
    parameter int DW = 29,
    parameter int VW = 13,
    parameter int QW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 busy,
    output logic signed [QW-1:0] quotient
);

    localparam int NW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [NW-1:0] step_reg, step_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] q_reg, q_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic signed [QW-1:0] quot_reg, quot_next;
    logic [VW:0]   trial;
    logic [DW-1:0] qmag;

    // One quotient bit per cycle, then the floor correction.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        trial     = {rem_reg[VW-1:0], q_reg[DW-1]};
        qmag      = '0;
        if (go)
        begin
            busy_next = 1'b1;
            step_next = NW'(DW);
            neg_next  = dividend[DW-1];
            q_next    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (step_reg != '0)
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = trial - {1'b0, dvs_reg};
                    q_next   = {q_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[DW-2:0], 1'b0};
                end
                step_next = step_reg - NW'(1);
            end
            else
            begin
                qmag = q_reg + DW'(neg_reg && (rem_reg != '0));
                quot_next = neg_reg ? QW'(-qmag) : QW'(qmag);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

/* sv/waveform_pulse_trigger_unit.sv */
// Top level of the pulse trigger unit: record load, trigger pass and result.
// Samples load at one item per cycle while busy is low. After the item marked
// last, busy stays high while the record is scanned: threshold setup in the
// PREP and RHS states, then one pass over the n stored samples through the
// two read ports of the sample store, which runs beside the mean division;
// a fired record with samples outside the exclusion zone adds a second
// division for the baseline. The result appears for one cycle on result_valid,
// which the receiver must take, and the next record may start the cycle after.
module waveform_pulse_trigger_unit #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  wptu_pkg::in_item_t                   item,
    output logic                                 result_valid,
    output wptu_pkg::out_item_t                  result,
    input  logic                                 cfg_we,
    input  logic [wptu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wptu_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int SB   = wptu_pkg::SAMPLE_BITS;
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int TW   = SB + CW;
    localparam int SWW  = SB + 9;
    localparam int PW   = SWW + CW + 1;
    localparam int LW   = PW + 8;
    localparam int P1W  = TW + 17;
    localparam int RW   = P1W + 9;
    localparam int CMPW = RW + LW;
    localparam int EW   = (CW > 12 ? CW : 12) + 1;

    // Configuration registers.
    logic [15:0] thr_reg;
    logic [7:0]  win_reg;
    logic [11:0] pre_reg;
    logic [11:0] post_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 16'd261;
            win_reg  <= 8'd10;
            pre_reg  <= 12'd50;
            post_reg <= 12'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wptu_pkg::REG_THRESHOLD: thr_reg  <= cfg_data;
                wptu_pkg::REG_WINDOW:    win_reg  <= cfg_data[7:0];
                wptu_pkg::REG_EXCL_PRE:  pre_reg  <= cfg_data[11:0];
                wptu_pkg::REG_EXCL_POST: post_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    wptu_pkg::state_t state_reg, state_next;

    logic accept;
    logic room;
    logic [CW-1:0]        count_reg;
    logic signed [TW-1:0] total_reg;
    logic signed [SB-1:0] peak_reg;
    logic [AW-1:0]        peak_idx_reg;
    logic                 ovf_reg;

    assign busy   = (state_reg != wptu_pkg::ST_LOAD);
    assign accept = start && !busy;
    assign room   = (count_reg < CW'(MAX_SAMPLES));

    // Sample store and its read side.
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_back;
    logic [SB-1:0] rd_a, rd_b;

    assign j_back = j_reg - CW'(win_reg);

    wptu_mem #(.DEPTH(MAX_SAMPLES), .AW(AW), .W(SB)) u_mem (
        .clk     (clk),
        .we      (accept && room),
        .waddr   (count_reg[AW-1:0]),
        .wdata   (item.sample),
        .raddr_a (j_reg[AW-1:0]),
        .raddr_b (j_back[AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Shared divider for mean and baseline.
    logic                 div_go;
    logic signed [TW-1:0] div_dvd;
    logic [CW-1:0]        div_dvs;
    logic                 div_busy;
    logic signed [SB-1:0] div_q;

    wptu_div #(.DW(TW), .VW(CW), .QW(SB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Record accumulation during load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            total_reg    <= '0;
            peak_reg     <= {1'b1, {(SB-1){1'b0}}};
            peak_idx_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (state_reg == wptu_pkg::ST_OUT)
        begin
            count_reg    <= '0;
            total_reg    <= '0;
            peak_reg     <= {1'b1, {(SB-1){1'b0}}};
            peak_idx_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (room)
            begin
                count_reg <= count_reg + CW'(1);
                total_reg <= total_reg + TW'(item.sample);
                if (item.sample > peak_reg)
                begin
                    peak_reg     <= item.sample;
                    peak_idx_reg <= count_reg[AW-1:0];
                end
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Threshold right side, in two multiply stages.
    logic signed [P1W-1:0] p1_reg;
    logic signed [RW-1:0]  rhs_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == wptu_pkg::ST_PREP)
        begin
            p1_reg <= P1W'(total_reg * $signed({1'b0, thr_reg}));
        end
        if (state_reg == wptu_pkg::ST_RHS)
        begin
            rhs_reg <= RW'(p1_reg * $signed({1'b0, win_reg}));
        end
    end

    // Scan pipeline: read, window sum, product, compare.
    logic                  s1_v_reg, s2_v_reg, s3_v_reg;
    logic                  s1_sub_reg;
    logic [CW-1:0]         s1_j_reg;
    logic signed [SWW-1:0] sum_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [TW-1:0]  acc_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  fired_reg;
    logic                  issue;
    logic                  excl_out;
    logic signed [CMPW-1:0] lhs_ext, rhs_ext;

    assign issue   = (state_reg == wptu_pkg::ST_PASS) && (j_reg != count_reg);
    assign excl_out = ((EW'(s1_j_reg) + EW'(pre_reg)) < EW'(peak_idx_reg))
                   || (EW'(s1_j_reg) > (EW'(peak_idx_reg) + EW'(post_reg)));
    assign lhs_ext = CMPW'($signed({prod_reg, 8'b0}));
    assign rhs_ext = CMPW'(rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            j_reg     <= '0;
            fired_reg <= 1'b0;
        end
        else if (state_reg == wptu_pkg::ST_PREP)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            j_reg     <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            if (issue)
            begin
                j_reg <= j_reg + CW'(1);
            end
            s2_v_reg <= s1_v_reg && (win_reg != 8'd0)
                     && ((s1_j_reg + CW'(1)) >= CW'(win_reg));
            s3_v_reg <= s2_v_reg;
            if (s3_v_reg && (lhs_ext > rhs_ext))
            begin
                fired_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_j_reg   <= j_reg;
        s1_sub_reg <= (j_reg >= CW'(win_reg));
        prod_reg   <= PW'(sum_reg * $signed({1'b0, count_reg}));
        if (state_reg == wptu_pkg::ST_PREP)
        begin
            sum_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (s1_v_reg)
        begin
            sum_reg <= sum_reg + SWW'($signed(rd_a))
                     - (s1_sub_reg ? SWW'($signed(rd_b)) : SWW'(0));
            if (excl_out)
            begin
                acc_reg <= acc_reg + TW'($signed(rd_a));
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // Result registers.
    logic signed [SB-1:0] mean_reg, mean_next;
    logic signed [SB-1:0] base_reg, base_next;

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        base_reg <= base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wptu_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        base_next  = base_reg;
        div_go     = 1'b0;
        div_dvd    = total_reg;
        div_dvs    = count_reg;
        unique case (state_reg)
            wptu_pkg::ST_LOAD:
            begin
                if (accept && item.last)
                begin
                    state_next = wptu_pkg::ST_PREP;
                end
            end
            wptu_pkg::ST_PREP:
            begin
                div_go     = 1'b1;
                state_next = wptu_pkg::ST_RHS;
            end
            wptu_pkg::ST_RHS:
            begin
                state_next = wptu_pkg::ST_PASS;
            end
            wptu_pkg::ST_PASS:
            begin
                if (!issue && !s1_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    state_next = wptu_pkg::ST_WAIT;
                end
            end
            wptu_pkg::ST_WAIT:
            begin
                if (!div_busy)
                begin
                    mean_next = div_q;
                    base_next = div_q;
                    if (fired_reg && (cnt_reg != '0))
                    begin
                        div_go     = 1'b1;
                        div_dvd    = acc_reg;
                        div_dvs    = cnt_reg;
                        state_next = wptu_pkg::ST_BDIV;
                    end
                    else
                    begin
                        state_next = wptu_pkg::ST_OUT;
                    end
                end
            end
            wptu_pkg::ST_BDIV:
            begin
                if (!div_busy)
                begin
                    base_next  = div_q;
                    state_next = wptu_pkg::ST_OUT;
                end
            end
            wptu_pkg::ST_OUT:
            begin
                state_next = wptu_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = wptu_pkg::ST_LOAD;
            end
        endcase
    end

    assign result_valid        = (state_reg == wptu_pkg::ST_OUT);
    assign result.mean         = mean_reg;
    assign result.max_index    = wptu_pkg::IDX_BITS'(peak_idx_reg);
    assign result.max_value    = peak_reg;
    assign result.fired        = fired_reg;
    assign result.baseline     = base_reg;
    assign result.sample_count = wptu_pkg::COUNT_BITS'(count_reg);
    assign result.overflow     = ovf_reg;

endmodule

/* sv/wptu_checker.sv */
// Port-level checker of the pulse trigger unit and its bind.
`include "waveform_pulse_trigger_unit_assert.svh"

module wptu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input wptu_pkg::in_item_t  item,
    input logic                result_valid,
    input wptu_pkg::out_item_t result
);

    // A result is a single-cycle strobe.
    `WPTU_ASSERT_NEXT(a_strobe_once, result_valid, !result_valid, "result strobe held")
    // A result is shown only while the block is busy.
    `WPTU_ASSERT_IMP(a_result_busy, result_valid, busy, "result while idle")
    // The block is free again right after the result.
    `WPTU_ASSERT_NEXT(a_free_after, result_valid, !busy, "busy after result")
    // A record never reports zero stored samples.
    `WPTU_ASSERT_IMP(a_count_nz, result_valid, result.sample_count != '0, "empty record")
    // A non-final item keeps the block taking samples.
    `WPTU_ASSERT_NEXT(a_load_on, start && !busy && !item.last, !busy && !result_valid,
        "stalled in load")

endmodule

bind waveform_pulse_trigger_unit wptu_checker u_wptu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

/* sim/tb.sv */
// Testbench of the pulse trigger unit: directed table, random records, own predictor.
`timescale 1ns / 1ps

module tb;

    localparam int  CAPACITY    = 4096;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  RANDOM_ITEMS = 1800;
    localparam logic [wptu_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 8'd200;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    wptu_pkg::in_item_t                 item;
    logic                               result_valid;
    wptu_pkg::out_item_t                result;
    logic                               cfg_we;
    logic [wptu_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [wptu_pkg::CFG_DATA_BITS-1:0] cfg_data;

    waveform_pulse_trigger_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Directed rows; a typed result is given where it is obvious.
    typedef struct {
        logic signed [15:0]  sample;
        logic                last;
        bit                  typed;
        wptu_pkg::out_item_t result;
    } row_t;

    // Predictor copy of the registers and the open record.
    int unsigned        thr_q8;
    int unsigned        win_len;
    int unsigned        excl_pre;
    int unsigned        excl_post;
    logic signed [15:0] rec_samples [CAPACITY];
    int                 rec_len;
    longint             rec_total;
    int                 rec_peak;
    int                 rec_peak_idx;
    bit                 rec_dropped;

    wptu_pkg::out_item_t expected_results[$];
    int        fail_count;
    int        cycle_count;
    bit        calm;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && (a < 0))
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic void clear_record();
        rec_len      = 0;
        rec_total    = 0;
        rec_peak     = -32768;
        rec_peak_idx = 0;
        rec_dropped  = 0;
    endfunction

    // Adds one item to the record and returns the result on the last item.
    function automatic bit trigger_predict(wptu_pkg::in_item_t it,
                                           output wptu_pkg::out_item_t res);
        longint n, mean, sum, rhs, base, acc, cnt, lo, hi;
        bit     hit;
        if (rec_len < CAPACITY)
        begin
            rec_samples[rec_len] = it.sample;
            rec_total = rec_total + it.sample;
            if (int'(it.sample) > rec_peak)
            begin
                rec_peak     = it.sample;
                rec_peak_idx = rec_len;
            end
            rec_len++;
        end
        else
        begin
            rec_dropped = 1;
        end
        if (!it.last)
        begin
            return 0;
        end
        n    = rec_len;
        mean = floor_div(rec_total, n);
        hit  = 0;
        base = mean;
        // Sliding window sum against the scaled mean.
        if (win_len > 0 && win_len <= n)
        begin
            rhs = rec_total * longint'(thr_q8) * longint'(win_len);
            sum = 0;
            for (int i = 0; i < win_len; i++)
            begin
                sum += rec_samples[i];
            end
            for (int i = 0; ; i++)
            begin
                if (sum * n * 256 > rhs)
                begin
                    hit = 1;
                end
                if (i + win_len >= n)
                begin
                    break;
                end
                sum = sum - rec_samples[i] + rec_samples[i + win_len];
            end
        end
        // Baseline from the samples outside the exclusion zone.
        if (hit)
        begin
            lo  = longint'(rec_peak_idx) - longint'(excl_pre);
            hi  = longint'(rec_peak_idx) + longint'(excl_post);
            acc = 0;
            cnt = 0;
            for (int i = 0; i < n; i++)
            begin
                if (i < lo || i > hi)
                begin
                    acc += rec_samples[i];
                    cnt++;
                end
            end
            if (cnt > 0)
            begin
                base = floor_div(acc, cnt);
            end
        end
        res.mean         = mean[15:0];
        res.max_index    = rec_peak_idx[11:0];
        res.max_value    = rec_peak[15:0];
        res.fired        = hit;
        res.baseline     = base[15:0];
        res.sample_count = rec_len[12:0];
        res.overflow     = rec_dropped;
        clear_record();
        return 1;
    endfunction

    // Presents one item and waits until it is taken, with random idle cycles.
    task automatic send_item(wptu_pkg::in_item_t it, bit typed,
                             wptu_pkg::out_item_t typed_res);
        wptu_pkg::out_item_t res;
        while (!calm && $urandom_range(99) < 11)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (trigger_predict(it, res))
        begin
            expected_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_sample(logic signed [15:0] s, logic last);
        wptu_pkg::in_item_t  it;
        wptu_pkg::out_item_t none;
        it.sample = s;
        it.last   = last;
        none      = '0;
        send_item(it, 0, none);
    endtask

    // Waits until every expected result has come and the unit has settled.
    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [wptu_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            wptu_pkg::REG_THRESHOLD: thr_q8    = val;
            wptu_pkg::REG_WINDOW:    win_len   = val[7:0];
            wptu_pkg::REG_EXCL_PRE:  excl_pre  = val[11:0];
            wptu_pkg::REG_EXCL_POST: excl_post = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] t, logic [15:0] w, logic [15:0] b,
                            logic [15:0] a);
        drain();
        write_reg(wptu_pkg::REG_THRESHOLD, t);
        write_reg(wptu_pkg::REG_WINDOW, w);
        write_reg(wptu_pkg::REG_EXCL_PRE, b);
        write_reg(wptu_pkg::REG_EXCL_POST, a);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One record of random shape: flat noise with an optional pulse, or raw values.
    task automatic send_record(int len);
        int  offset, amp, noise, pos, width, v;
        bit  raw;
        raw    = ($urandom_range(9) == 0);
        offset = $urandom_range(4000) - 500;
        noise  = $urandom_range(200);
        amp    = ($urandom_range(3) == 0) ? 0 : $urandom_range(20000);
        pos    = $urandom_range(len - 1);
        width  = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
        begin
            if (raw)
            begin
                v = $signed(16'($urandom));
            end
            else
            begin
                v = offset + $urandom_range(2 * noise) - noise;
                if (i >= pos && i < pos + width)
                begin
                    v = v + amp;
                end
                if (v > 32767)
                begin
                    v = 32767;
                end
            end
            send_sample(v[15:0], i == len - 1);
        end
    endtask

    // Results are taken at the edge that ends their cycle.
    always @(posedge clk)
    begin
        wptu_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result !== want)
                begin
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, want, result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        row_t directed[$];
        row_t r;
        int   sent;
        int   len;

        fail_count  = 0;
        cycle_count = 0;
        calm        = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        thr_q8      = 261;
        win_len     = 10;
        excl_pre    = 50;
        excl_post   = 100;
        clear_record();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-sample records at the extremes, readable by eye.
        r = '{16'sh7FFF, 1'b1, 1, '{16'sh7FFF, 12'd0, 16'sh7FFF, 1'b0, 16'sh7FFF, 13'd1, 1'b0}};
        directed.push_back(r);
        r = '{16'sh8000, 1'b1, 1, '{16'sh8000, 12'd0, 16'sh8000, 1'b0, 16'sh8000, 13'd1, 1'b0}};
        directed.push_back(r);
        r = '{16'sh0000, 1'b1, 1, '{16'sh0000, 12'd0, 16'sh0000, 1'b0, 16'sh0000, 13'd1, 1'b0}};
        directed.push_back(r);
        // Equal maxima with a negative floor mean.
        r = '{-16'sd3, 1'b0, 0, '0};
        directed.push_back(r);
        r = '{16'sd5, 1'b0, 0, '0};
        directed.push_back(r);
        r = '{16'sd5, 1'b0, 0, '0};
        directed.push_back(r);
        r = '{-16'sd8, 1'b1, 0, '0};
        directed.push_back(r);
        // A pulse long enough to fire with the reset registers.
        for (int i = 0; i < 14; i++)
        begin
            r = '{(i >= 4 && i < 8) ? 16'sd900 : 16'sd100, i == 13, 0, '0};
            directed.push_back(r);
        end
        foreach (directed[k])
        begin
            send_item('{directed[k].sample, directed[k].last},
                      directed[k].typed, directed[k].result);
        end

        // A stray register index is ignored, and the sender waits for all results.
        drain();
        write_reg(REG_UNUSED, 16'h0001);
        cfg_we <= 1'b0;
        send_record(12);

        // Register extremes: widest values, masked writes, zero window and zones.
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_record(40);
        send_record(300);
        set_regs(16'h0000, 16'h0100, 16'h0000, 16'h0000);
        send_record(20);
        set_regs(16'h0100, 16'h0001, 16'h0000, 16'h0000);
        send_record(1);
        send_record(30);
        set_regs(16'h0000, 16'h0001, 16'h0FFF, 16'h0FFF);
        send_record(25);

        // Full and overflowing records at the default-like settings.
        set_regs(16'd261, 16'd10, 16'd50, 16'd100);
        send_record(CAPACITY);
        send_record(CAPACITY + 5);

        // Random records with a register change every so often.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(15) == 0)
            begin
                set_regs(16'($urandom_range(512)), 16'($urandom_range(1, 40)),
                         16'($urandom_range(60)), 16'($urandom_range(60)));
            end
            calm = (sent > 700 && sent < 1000);
            case ($urandom_range(19))
                0:       len = $urandom_range(41, 400);
                1:       len = $urandom_range(1, 3);
                default: len = $urandom_range(4, 40);
            endcase
            send_record(len);
            sent += len;
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* waveform_pulse_trigger_unit.f */
+incdir+sv
sv/wptu_pkg.sv
sv/wptu_mem.sv
sv/wptu_div.sv
sv/waveform_pulse_trigger_unit.sv
sv/wptu_checker.sv
sim/tb.sv
